// File: hdl/jsu_pkg.sv
// Shared types, status codes and helpers for the JSON string unescaper.
package jsu_pkg;

    // Result status codes
    localparam logic [1:0] ST_DATA   = 2'd0;
    localparam logic [1:0] ST_OK     = 2'd1;
    localparam logic [1:0] ST_FORMAT = 2'd2;
    localparam logic [1:0] ST_LARGE  = 2'd3;

    // Decoded byte limit per payload and length counter width
    localparam int LEN_W         = 13;
    localparam int MAX_OUT_BYTES = 4096;

    // Code point width (up to U+10FFFF)
    localparam int CP_W = 21;

    // Command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // One command: either a code point to emit as 1 to 4 UTF-8 bytes,
    // or an end-of-payload record (status other than data)
    typedef struct packed {
        logic [CP_W-1:0]  cp;
        logic [2:0]       nbytes;
        logic [1:0]       status;
        logic [LEN_W-1:0] len;
    } t_cmd;

    // Byte k of the UTF-8 encoding of cp, which is n bytes long
    function automatic logic [7:0] utf8_byte(logic [CP_W-1:0] cp, logic [2:0] n,
                                             logic [1:0] k);
        logic [7:0] b;
        b = cp[7:0];
        case (n)
            3'd2: begin
                b = (k == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            end
            3'd3: begin
                case (k)
                    2'd0:    b = {4'b1110, cp[15:12]};
                    2'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            3'd4: begin
                case (k)
                    2'd0:    b = {5'b11110, cp[20:18]};
                    2'd1:    b = {2'b10, cp[17:12]};
                    2'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default: b = cp[7:0];
        endcase
        return b;
    endfunction

endpackage

// File: hdl/jsu_front.sv
// Front end: parses the quoted string byte by byte and issues commands.
module jsu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_in_byte,
    input  logic          i_in_last,
    output logic          o_cmd_valid,
    output jsu_pkg::t_cmd o_cmd
);

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [13:0] MAX_B = 14'(jsu_pkg::MAX_OUT_BYTES);

    typedef enum logic [8:0] {
        PH_OPEN     = 9'b000000001,
        PH_BODY     = 9'b000000010,
        PH_ESC      = 9'b000000100,
        PH_HEX_A    = 9'b000001000,
        PH_LOW_BSL  = 9'b000010000,
        PH_LOW_U    = 9'b000100000,
        PH_HEX_B    = 9'b001000000,
        PH_OVERFLOW = 9'b010000000,
        PH_DISCARD  = 9'b100000000
    } t_phase;

    t_phase                    r_phase, n_phase;
    logic [2:0]                r_hex_count, n_hex_count;
    logic [15:0]               r_code_accum, n_code_accum;
    logic [9:0]                r_high_half, n_high_half;
    logic [jsu_pkg::LEN_W-1:0] r_bytes_written, n_bytes_written;

    // Hex digit value; bit 4 flags a non-hex byte
    function automatic logic [4:0] hex_value(logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39)      v = {1'b0, c[3:0]};
        else if (c >= 8'h61 && c <= 8'h66) v = {1'b0, c[3:0] + 4'd9};
        else if (c >= 8'h41 && c <= 8'h46) v = {1'b0, c[3:0] + 4'd9};
        return v;
    endfunction

    logic [4:0]  hex_d;
    logic [15:0] acc_new;
    logic [2:0]  hc_new;
    logic [8:0]  esc_v;
    logic [20:0] pair_cp;
    logic [2:0]  bmp_n;
    logic [13:0] bw_ext;

    always_comb begin
        hex_d   = hex_value(i_in_byte);
        acc_new = {r_code_accum[11:0], hex_d[3:0]};
        hc_new  = r_hex_count + 3'd1;
        pair_cp = 21'h10000 + {1'b0, r_high_half, acc_new[9:0]};
        bw_ext  = {1'b0, r_bytes_written};
        if (acc_new < 16'h0080)      bmp_n = 3'd1;
        else if (acc_new < 16'h0800) bmp_n = 3'd2;
        else                         bmp_n = 3'd3;
        // Simple escape letters; bit 8 set when the letter is not one
        case (i_in_byte)
            CH_QUOTE, CH_BSL, CH_SLASH: esc_v = {1'b0, i_in_byte};
            CH_B:    esc_v = 9'h008;
            CH_F:    esc_v = 9'h00c;
            CH_N:    esc_v = 9'h00a;
            CH_R:    esc_v = 9'h00d;
            CH_T:    esc_v = 9'h009;
            default: esc_v = 9'h100;
        endcase
    end

    // Next state and command
    always_comb begin
        n_phase         = r_phase;
        n_hex_count     = r_hex_count;
        n_code_accum    = r_code_accum;
        n_high_half     = r_high_half;
        n_bytes_written = r_bytes_written;
        o_cmd_valid     = 1'b0;
        o_cmd.cp        = '0;
        o_cmd.nbytes    = 3'd1;
        o_cmd.status    = jsu_pkg::ST_FORMAT;
        o_cmd.len       = '0;

        case (r_phase)
            PH_OPEN: begin
                if (i_in_byte == CH_QUOTE && !i_in_last) begin
                    n_phase         = PH_BODY;
                    n_bytes_written = '0;
                    n_hex_count     = '0;
                    n_code_accum    = '0;
                    n_high_half     = '0;
                end else begin
                    o_cmd_valid = 1'b1;
                    n_phase     = i_in_last ? PH_OPEN : PH_DISCARD;
                end
            end
            PH_BODY: begin
                if (i_in_last) begin
                    o_cmd_valid = 1'b1;
                    n_phase     = PH_OPEN;
                    if (i_in_byte == CH_QUOTE) begin
                        o_cmd.status = jsu_pkg::ST_OK;
                        o_cmd.len    = r_bytes_written;
                    end
                end else if (i_in_byte == CH_BSL) begin
                    n_phase = PH_ESC;
                end else if (i_in_byte < CH_SPACE || bw_ext >= MAX_B) begin
                    o_cmd_valid = 1'b1;
                    n_phase     = PH_DISCARD;
                end else begin
                    o_cmd_valid     = 1'b1;
                    o_cmd.status    = jsu_pkg::ST_DATA;
                    o_cmd.cp        = {13'd0, i_in_byte};
                    n_bytes_written = r_bytes_written + 13'd1;
                end
            end
            PH_ESC: begin
                if (i_in_last) begin
                    o_cmd_valid = 1'b1;
                    n_phase     = PH_OPEN;
                end else if (!esc_v[8]) begin
                    if (bw_ext >= MAX_B) begin
                        n_phase = PH_OVERFLOW;
                    end else begin
                        o_cmd_valid     = 1'b1;
                        o_cmd.status    = jsu_pkg::ST_DATA;
                        o_cmd.cp        = {13'd0, esc_v[7:0]};
                        n_bytes_written = r_bytes_written + 13'd1;
                        n_phase         = PH_BODY;
                    end
                end else if (i_in_byte == CH_U) begin
                    n_hex_count  = '0;
                    n_code_accum = '0;
                    n_phase      = PH_HEX_A;
                end else begin
                    o_cmd_valid = 1'b1;
                    n_phase     = PH_DISCARD;
                end
            end
            PH_HEX_A, PH_HEX_B: begin
                if (i_in_last || hex_d[4]) begin
                    o_cmd_valid = 1'b1;
                    n_phase     = i_in_last ? PH_OPEN : PH_DISCARD;
                end else if (hc_new != 3'd4) begin
                    n_code_accum = acc_new;
                    n_hex_count  = hc_new;
                end else begin
                    n_hex_count  = '0;
                    n_code_accum = '0;
                    if (r_phase == PH_HEX_A) begin
                        if (acc_new[15:10] == 6'b110110) begin
                            // High surrogate: wait for the low half
                            n_high_half = acc_new[9:0];
                            n_phase     = PH_LOW_BSL;
                        end else if (acc_new[15:10] == 6'b110111) begin
                            o_cmd_valid = 1'b1;
                            n_phase     = PH_DISCARD;
                        end else if (bw_ext + {11'd0, bmp_n} > MAX_B) begin
                            n_phase = PH_OVERFLOW;
                        end else begin
                            o_cmd_valid     = 1'b1;
                            o_cmd.status    = jsu_pkg::ST_DATA;
                            o_cmd.cp        = {5'd0, acc_new};
                            o_cmd.nbytes    = bmp_n;
                            n_bytes_written = r_bytes_written + {10'd0, bmp_n};
                            n_phase         = PH_BODY;
                        end
                    end else begin
                        if (acc_new[15:10] != 6'b110111) begin
                            o_cmd_valid = 1'b1;
                            n_phase     = PH_DISCARD;
                        end else if (bw_ext + 14'd4 > MAX_B) begin
                            n_phase = PH_OVERFLOW;
                        end else begin
                            o_cmd_valid     = 1'b1;
                            o_cmd.status    = jsu_pkg::ST_DATA;
                            o_cmd.cp        = pair_cp;
                            o_cmd.nbytes    = 3'd4;
                            n_bytes_written = r_bytes_written + 13'd4;
                            n_phase         = PH_BODY;
                        end
                    end
                end
            end
            PH_LOW_BSL: begin
                if (i_in_last || i_in_byte != CH_BSL) begin
                    o_cmd_valid = 1'b1;
                    n_phase     = i_in_last ? PH_OPEN : PH_DISCARD;
                end else begin
                    n_phase = PH_LOW_U;
                end
            end
            PH_LOW_U: begin
                if (i_in_last || i_in_byte != CH_U) begin
                    o_cmd_valid = 1'b1;
                    n_phase     = i_in_last ? PH_OPEN : PH_DISCARD;
                end else begin
                    n_hex_count  = '0;
                    n_code_accum = '0;
                    n_phase      = PH_HEX_B;
                end
            end
            PH_OVERFLOW: begin
                if (i_in_last) begin
                    o_cmd_valid  = 1'b1;
                    o_cmd.status = (i_in_byte == CH_QUOTE) ? jsu_pkg::ST_LARGE
                                                           : jsu_pkg::ST_FORMAT;
                    n_phase      = PH_OPEN;
                end
            end
            default: begin
                n_phase = i_in_last ? PH_OPEN : PH_DISCARD;
            end
        endcase
    end

    // State registers, updated only on an accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_OPEN;
            r_hex_count     <= '0;
            r_code_accum    <= '0;
            r_high_half     <= '0;
            r_bytes_written <= '0;
        end else if (i_accept) begin
            r_phase         <= n_phase;
            r_hex_count     <= n_hex_count;
            r_code_accum    <= n_code_accum;
            r_high_half     <= n_high_half;
            r_bytes_written <= n_bytes_written;
        end
    end

endmodule

// File: hdl/jsu_queue.sv
// Short command queue between the parsing front end and the byte emitter.
module jsu_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  jsu_pkg::t_cmd i_wr_cmd,
    input  logic          i_rd,
    output jsu_pkg::t_cmd o_rd_cmd,
    output logic          o_full,
    output logic          o_empty
);

    jsu_pkg::t_cmd             r_mem [jsu_pkg::Q_DEPTH];
    logic [jsu_pkg::Q_AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [jsu_pkg::Q_AW:0]    r_count, n_count;

    assign o_full   = (r_count == (jsu_pkg::Q_AW+1)'(jsu_pkg::Q_DEPTH));
    assign o_empty  = (r_count == '0);
    assign o_rd_cmd = r_mem[r_rd_ptr];

    // Occupancy
    always_comb begin
        n_count = r_count;
        if (i_wr && !i_rd)      n_count = r_count + (jsu_pkg::Q_AW+1)'(1);
        else if (!i_wr && i_rd) n_count = r_count - (jsu_pkg::Q_AW+1)'(1);
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

    // Pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) r_wr_ptr <= r_wr_ptr + jsu_pkg::Q_AW'(1);
            if (i_rd) r_rd_ptr <= r_rd_ptr + jsu_pkg::Q_AW'(1);
            r_count <= n_count;
        end
    end

endmodule

// File: hdl/jsu_back.sv
// Back end: expands queued commands into result transactions, one per cycle while the receiver pops.
module jsu_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  jsu_pkg::t_cmd             i_cmd,
    input  logic                      i_q_empty,
    output logic                      o_q_pop,
    input  logic                      i_pop,
    output logic                      o_valid,
    output logic [7:0]                o_out_byte,
    output logic [1:0]                o_status,
    output logic [jsu_pkg::LEN_W-1:0] o_total_length,
    output logic                      o_last
);

    logic                      r_valid;
    logic [1:0]                r_idx;
    logic [7:0]                r_byte;
    logic [1:0]                r_status;
    logic [jsu_pkg::LEN_W-1:0] r_len;
    logic                      r_last;

    logic load;
    logic is_data;
    logic cmd_done;

    // Output register can take a new result when empty or being drained
    always_comb begin
        load     = (!r_valid || i_pop) && !i_q_empty;
        is_data  = (i_cmd.status == jsu_pkg::ST_DATA);
        cmd_done = !is_data || ({1'b0, r_idx} == i_cmd.nbytes - 3'd1);
        o_q_pop  = load && cmd_done;
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte   <= is_data ? jsu_pkg::utf8_byte(i_cmd.cp, i_cmd.nbytes, r_idx) : 8'd0;
            r_status <= i_cmd.status;
            r_len    <= is_data ? '0 : i_cmd.len;
            r_last   <= !is_data;
        end
    end

    // Valid flag and byte index within the current command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= cmd_done ? 2'd0 : r_idx + 2'd1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_out_byte     = r_byte;
    assign o_status       = r_status;
    assign o_total_length = r_len;
    assign o_last         = r_last;

endmodule

// File: hdl/json_string_unescape_utf8_top.sv
// Top level of the JSON string unescaper with UTF-8 output.
//
// Input channel: one byte of a quoted JSON string per transaction, taken
// when push is high and full is low; i_in_last marks the closing byte.
// Result channel: a queue interface; while empty is low the oldest result
// sits on o_out_byte, o_status, o_total_length and o_last, and pop takes it.
// Each payload gives its decoded bytes (status data) and then one record
// with o_last set: ended ok with the byte count, format error or too large.
// After an error the consumer drops the bytes already delivered.
// A result passes through the command queue and the output register on its
// way to the ports. Throughput: one byte per cycle in while full is low, one
// result per cycle out while the receiver pops; a \u escape yields up to 3
// results over 6 input bytes and a surrogate pair 4 results over 12, and the
// four-entry command queue between parser and emitter absorbs this.
// When the receiver stalls, the output register and the queue fill and
// full rises; no result is lost. Reset (synchronous, active low) empties
// the queue and output register and waits for an opening quote.
module json_string_unescape_utf8_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [7:0]                i_in_byte,
    input  logic                      i_in_last,
    output logic                      empty,
    input  logic                      pop,
    output logic [7:0]                o_out_byte,
    output logic [1:0]                o_status,
    output logic [jsu_pkg::LEN_W-1:0] o_total_length,
    output logic                      o_last
);

    logic          accept;
    logic          cmd_valid;
    jsu_pkg::t_cmd cmd_in;
    jsu_pkg::t_cmd cmd_head;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;
    logic          out_valid;

    assign accept = push && !q_full;
    assign full   = q_full;
    assign empty  = !out_valid;

    jsu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd_in)
    );

    jsu_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (accept && cmd_valid),
        .i_wr_cmd (cmd_in),
        .i_rd     (q_pop),
        .o_rd_cmd (cmd_head),
        .o_full   (q_full),
        .o_empty  (q_empty)
    );

    jsu_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd_head),
        .i_q_empty      (q_empty),
        .o_q_pop        (q_pop),
        .i_pop          (pop),
        .o_valid        (out_valid),
        .o_out_byte     (o_out_byte),
        .o_status       (o_status),
        .o_total_length (o_total_length),
        .o_last         (o_last)
    );

endmodule

// File: tb/json_string_unescape_utf8_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the JSON string unescaper: directed table, random payloads.
module json_string_unescape_utf8_top_tb;

    localparam int HOLD_CYCLES = 80;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 20;
    localparam int PHASE_ITEMS = 32;

    // Idle percentages per random phase: none, sender, receiver, both
    localparam int SEND_IDLE [4] = '{0, 88, 0, 29};
    localparam int RECV_STALL[4] = '{0, 0, 88, 29};

    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSL     = 8'h5c;
    localparam logic [7:0] CH_U       = 8'h75;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;

    typedef enum logic [8:0] {
        PH_OPEN     = 9'b000000001,
        PH_BODY     = 9'b000000010,
        PH_ESC      = 9'b000000100,
        PH_HEX_HI   = 9'b000001000,
        PH_LOW_BSL  = 9'b000010000,
        PH_LOW_U    = 9'b000100000,
        PH_HEX_LO   = 9'b001000000,
        PH_OVERFLOW = 9'b010000000,
        PH_DISCARD  = 9'b100000000
    } t_dec_phase;

    // How a directed row is checked
    typedef enum logic [1:0] {ROW_PREDICT, ROW_QUIET, ROW_RECORD} t_row_kind;

    typedef struct packed {
        logic [7:0]               data;
        logic [1:0]               status;
        logic [jsu_pkg::LEN_W-1:0] len;
        logic                     last;
    } t_result;

    typedef struct packed {
        logic [7:0]               b;
        logic                     l;
        t_row_kind                kind;
        logic [1:0]               status;
        logic [jsu_pkg::LEN_W-1:0] len;
    } t_dir_row;

    // Directed stimulus; typed rows carry the end record or no result
    localparam t_dir_row DIR_TAB [26] = '{
        '{CH_QUOTE, 1'b1, ROW_RECORD, jsu_pkg::ST_FORMAT, 13'd0},  // opening quote marked last
        '{8'h00,    1'b0, ROW_RECORD, jsu_pkg::ST_FORMAT, 13'd0},  // bad opening byte
        '{8'hff,    1'b1, ROW_QUIET,  jsu_pkg::ST_DATA,   13'd0},  // discarded up to last
        '{CH_QUOTE, 1'b0, ROW_QUIET,  jsu_pkg::ST_DATA,   13'd0},
        '{8'hff,    1'b0, ROW_PREDICT, jsu_pkg::ST_DATA,  13'd0},
        '{CH_BSL,   1'b0, ROW_QUIET,  jsu_pkg::ST_DATA,   13'd0},  // high surrogate DBFF
        '{CH_U,     1'b0, ROW_QUIET,  jsu_pkg::ST_DATA,   13'd0},
        '{"D",      1'b0, ROW_QUIET,  jsu_pkg::ST_DATA,   13'd0},
        '{"B",      1'b0, ROW_QUIET,  jsu_pkg::ST_DATA,   13'd0},
        '{"F",      1'b0, ROW_QUIET,  jsu_pkg::ST_DATA,   13'd0},
        '{"F",      1'b0, ROW_QUIET,  jsu_pkg::ST_DATA,   13'd0},
        '{CH_BSL,   1'b0, ROW_QUIET,  jsu_pkg::ST_DATA,   13'd0},  // low surrogate dfff
        '{CH_U,     1'b0, ROW_QUIET,  jsu_pkg::ST_DATA,   13'd0},
        '{"d",      1'b0, ROW_QUIET,  jsu_pkg::ST_DATA,   13'd0},
        '{"f",      1'b0, ROW_QUIET,  jsu_pkg::ST_DATA,   13'd0},
        '{"f",      1'b0, ROW_QUIET,  jsu_pkg::ST_DATA,   13'd0},
        '{"f",      1'b0, ROW_PREDICT, jsu_pkg::ST_DATA,  13'd0},  // U+10FFFF, four bytes
        '{CH_QUOTE, 1'b1, ROW_RECORD, jsu_pkg::ST_OK,     13'd5},
        '{CH_QUOTE, 1'b0, ROW_QUIET,  jsu_pkg::ST_DATA,   13'd0},
        '{CH_BSL,   1'b0, ROW_QUIET,  jsu_pkg::ST_DATA,   13'd0},  // lone low surrogate
        '{CH_U,     1'b0, ROW_QUIET,  jsu_pkg::ST_DATA,   13'd0},
        '{"d",      1'b0, ROW_QUIET,  jsu_pkg::ST_DATA,   13'd0},
        '{"c",      1'b0, ROW_QUIET,  jsu_pkg::ST_DATA,   13'd0},
        '{"0",      1'b0, ROW_QUIET,  jsu_pkg::ST_DATA,   13'd0},
        '{"0",      1'b0, ROW_RECORD, jsu_pkg::ST_FORMAT, 13'd0},
        '{"q",      1'b1, ROW_QUIET,  jsu_pkg::ST_DATA,   13'd0}
    };

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      push = 1'b0;
    logic [7:0]                i_in_byte = 8'h00;
    logic                      i_in_last = 1'b0;
    logic                      pop = 1'b0;
    logic                      full;
    logic                      empty;
    logic [7:0]                o_out_byte;
    logic [1:0]                o_status;
    logic [jsu_pkg::LEN_W-1:0] o_total_length;
    logic                      o_last;

    // Decoder state mirrored by the predictor
    t_dec_phase  dec_phase = PH_OPEN;
    int unsigned dec_hex_cnt = 0;
    logic [15:0] dec_code = '0;
    logic [9:0]  dec_high = '0;
    int unsigned dec_written = 0;

    t_result     step_out[$];
    t_result     decoded_q[$];
    logic [7:0]  frame[$];
    int          mismatch_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_reqs = 0;
    int          hold_seen = 0;
    int          quiet_cycles = 0;

    json_string_unescape_utf8_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_in_byte      (i_in_byte),
        .i_in_last      (i_in_last),
        .empty          (empty),
        .pop            (pop),
        .o_out_byte     (o_out_byte),
        .o_status       (o_status),
        .o_total_length (o_total_length),
        .o_last         (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------- predictor ----------------

    function automatic void put_rec(logic [7:0] d, logic [1:0] st, int unsigned n, logic l);
        step_out.push_back(t_result'{d, st, n[jsu_pkg::LEN_W-1:0], l});
    endfunction

    function automatic void format_fail(logic lst);
        put_rec(8'h00, jsu_pkg::ST_FORMAT, 0, 1'b1);
        dec_phase = lst ? PH_OPEN : PH_DISCARD;
    endfunction

    function automatic int hex_val(logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - 8'h30;
        if (c >= "a" && c <= "f") return int'(c) - 8'h61 + 10;
        if (c >= "A" && c <= "F") return int'(c) - 8'h41 + 10;
        return -1;
    endfunction

    // UTF-8 bytes of a code point; nothing goes out if the payload would overflow
    function automatic bit emit_utf8(int unsigned cp);
        int unsigned n;
        n = cp < 'h80 ? 1 : cp < 'h800 ? 2 : cp < 'h10000 ? 3 : 4;
        if (dec_written + n > jsu_pkg::MAX_OUT_BYTES) return 1'b0;
        case (n)
            1: put_rec(8'(cp), jsu_pkg::ST_DATA, 0, 1'b0);
            2: begin
                put_rec(8'('hc0 | (cp >> 6)), jsu_pkg::ST_DATA, 0, 1'b0);
                put_rec(8'('h80 | (cp & 'h3f)), jsu_pkg::ST_DATA, 0, 1'b0);
            end
            3: begin
                put_rec(8'('he0 | (cp >> 12)), jsu_pkg::ST_DATA, 0, 1'b0);
                put_rec(8'('h80 | ((cp >> 6) & 'h3f)), jsu_pkg::ST_DATA, 0, 1'b0);
                put_rec(8'('h80 | (cp & 'h3f)), jsu_pkg::ST_DATA, 0, 1'b0);
            end
            default: begin
                put_rec(8'('hf0 | (cp >> 18)), jsu_pkg::ST_DATA, 0, 1'b0);
                put_rec(8'('h80 | ((cp >> 12) & 'h3f)), jsu_pkg::ST_DATA, 0, 1'b0);
                put_rec(8'('h80 | ((cp >> 6) & 'h3f)), jsu_pkg::ST_DATA, 0, 1'b0);
                put_rec(8'('h80 | (cp & 'h3f)), jsu_pkg::ST_DATA, 0, 1'b0);
            end
        endcase
        dec_written += n;
        return 1'b1;
    endfunction

    // One accepted byte: results land in step_out
    function automatic void unescape_byte(logic [7:0] c, logic lst);
        int          d;
        logic [7:0]  v;
        bit          simple;
        int unsigned cp;
        step_out.delete();
        case (dec_phase)
            PH_OPEN: begin
                if (c == CH_QUOTE && !lst) begin
                    dec_phase = PH_BODY;
                    dec_written = 0;
                    dec_hex_cnt = 0;
                    dec_code = '0;
                    dec_high = '0;
                end else begin
                    format_fail(lst);
                end
            end
            PH_BODY: begin
                if (lst) begin
                    if (c == CH_QUOTE) begin
                        put_rec(8'h00, jsu_pkg::ST_OK, dec_written, 1'b1);
                        dec_phase = PH_OPEN;
                    end else begin
                        format_fail(1'b1);
                    end
                end else if (c == CH_BSL) begin
                    dec_phase = PH_ESC;
                end else if (c < CTRL_LIMIT || dec_written >= jsu_pkg::MAX_OUT_BYTES) begin
                    format_fail(1'b0);
                end else begin
                    put_rec(c, jsu_pkg::ST_DATA, 0, 1'b0);
                    dec_written++;
                end
            end
            PH_ESC: begin
                simple = 1'b1;
                case (c)
                    CH_QUOTE, CH_BSL, "/": v = c;
                    "b":     v = 8'h08;
                    "f":     v = 8'h0c;
                    "n":     v = 8'h0a;
                    "r":     v = 8'h0d;
                    "t":     v = 8'h09;
                    default: begin
                        v = 8'h00;
                        simple = 1'b0;
                    end
                endcase
                if (lst) begin
                    format_fail(1'b1);
                end else if (simple) begin
                    if (dec_written >= jsu_pkg::MAX_OUT_BYTES) begin
                        dec_phase = PH_OVERFLOW;
                    end else begin
                        put_rec(v, jsu_pkg::ST_DATA, 0, 1'b0);
                        dec_written++;
                        dec_phase = PH_BODY;
                    end
                end else if (c == CH_U) begin
                    dec_hex_cnt = 0;
                    dec_code = '0;
                    dec_phase = PH_HEX_HI;
                end else begin
                    format_fail(1'b0);
                end
            end
            PH_HEX_HI, PH_HEX_LO: begin
                d = hex_val(c);
                if (lst || d < 0) begin
                    format_fail(lst);
                end else begin
                    dec_code = {dec_code[11:0], 4'(d)};
                    dec_hex_cnt++;
                    if (dec_hex_cnt == 4) begin
                        dec_hex_cnt = 0;
                        if (dec_phase == PH_HEX_HI) begin
                            if (dec_code >= 16'hd800 && dec_code <= 16'hdbff) begin
                                dec_high = 10'(dec_code - 16'hd800);
                                dec_phase = PH_LOW_BSL;
                            end else if (dec_code >= 16'hdc00 && dec_code <= 16'hdfff) begin
                                format_fail(1'b0);
                            end else begin
                                dec_phase = emit_utf8(dec_code) ? PH_BODY : PH_OVERFLOW;
                            end
                        end else if (dec_code < 16'hdc00 || dec_code > 16'hdfff) begin
                            format_fail(1'b0);
                        end else begin
                            cp = 'h10000 + (int'(dec_high) << 10) + (dec_code - 16'hdc00);
                            dec_phase = emit_utf8(cp) ? PH_BODY : PH_OVERFLOW;
                        end
                        dec_code = '0;
                    end
                end
            end
            PH_LOW_BSL: begin
                if (lst || c != CH_BSL) format_fail(lst);
                else dec_phase = PH_LOW_U;
            end
            PH_LOW_U: begin
                if (lst || c != CH_U) begin
                    format_fail(lst);
                end else begin
                    dec_hex_cnt = 0;
                    dec_code = '0;
                    dec_phase = PH_HEX_LO;
                end
            end
            PH_OVERFLOW: begin
                if (lst) begin
                    put_rec(8'h00, (c == CH_QUOTE) ? jsu_pkg::ST_LARGE : jsu_pkg::ST_FORMAT,
                            0, 1'b1);
                    dec_phase = PH_OPEN;
                end
            end
            default: dec_phase = lst ? PH_OPEN : PH_DISCARD;
        endcase
    endfunction

    // ---------------- payload generation ----------------

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10) return 8'h30 + n;
        if ($urandom_range(1)) return 8'h61 + n - 8'd10;
        return 8'h41 + n - 8'd10;
    endfunction

    function automatic void add_uesc(logic [15:0] v);
        frame.push_back(CH_BSL);
        frame.push_back(CH_U);
        frame.push_back(hex_char(v[15:12]));
        frame.push_back(hex_char(v[11:8]));
        frame.push_back(hex_char(v[7:4]));
        frame.push_back(hex_char(v[3:0]));
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255, 32)); while (b == CH_BSL);
        return b;
    endfunction

    // Fresh frame: opening quote and a run of plain bytes
    function automatic void open_frame(int n_plain);
        frame.delete();
        frame.push_back(CH_QUOTE);
        repeat (n_plain) frame.push_back(plain_byte());
    endfunction

    function automatic void add_good_token();
        logic [7:0]  esc_set [8];
        logic [15:0] v;
        esc_set = '{CH_QUOTE, CH_BSL, "/", "b", "f", "n", "r", "t"};
        case ($urandom_range(9))
            0, 1, 2, 3: frame.push_back(plain_byte());
            4, 5: begin
                frame.push_back(CH_BSL);
                frame.push_back(esc_set[$urandom_range(7)]);
            end
            6: add_uesc(16'($urandom_range(16'h7f)));
            7: add_uesc(16'($urandom_range(16'h7ff, 16'h80)));
            8: begin
                v = 16'($urandom_range(16'hf7ff, 16'h800));
                if (v >= 16'hd800) v += 16'h800;
                add_uesc(v);
            end
            default: begin
                add_uesc(16'hd800 + 16'($urandom_range(10'h3ff)));
                add_uesc(16'hdc00 + 16'($urandom_range(10'h3ff)));
            end
        endcase
    endfunction

    // Malformed pieces: bad letter, bad hex, lone or misordered surrogate, control byte
    function automatic void add_bad_token();
        logic [7:0]  b;
        logic [15:0] v;
        case ($urandom_range(5))
            0: begin
                frame.push_back(CH_BSL);
                do b = 8'($urandom_range(255));
                while (b inside {CH_QUOTE, CH_BSL, "/", "b", "f", "n", "r", "t", CH_U});
                frame.push_back(b);
            end
            1: begin
                frame.push_back(CH_BSL);
                frame.push_back(CH_U);
                repeat ($urandom_range(3)) frame.push_back(hex_char(4'($urandom_range(15))));
                do b = 8'($urandom_range(255)); while (hex_val(b) >= 0);
                frame.push_back(b);
            end
            2: add_uesc(16'hdc00 + 16'($urandom_range(10'h3ff)));
            3: begin
                add_uesc(16'hd800 + 16'($urandom_range(10'h3ff)));
                if ($urandom_range(1)) begin
                    frame.push_back(plain_byte());
                end else begin
                    frame.push_back(CH_BSL);
                    frame.push_back("n");
                end
            end
            4: begin
                add_uesc(16'hd800 + 16'($urandom_range(10'h3ff)));
                do v = 16'($urandom_range(16'hffff)); while (v >= 16'hdc00 && v <= 16'hdfff);
                add_uesc(v);
            end
            default: frame.push_back(8'($urandom_range(31)));
        endcase
    endfunction

    // Mostly well-formed payloads, the rest broken, cut short, corrupted or garbage
    function automatic void build_frame();
        int r;
        int ntok;
        int bad_at;
        int cut;
        int k;
        r = $urandom_range(99);
        if (r >= 95) begin
            frame.delete();
            repeat ($urandom_range(5, 1)) frame.push_back(8'($urandom_range(255)));
            return;
        end
        open_frame(0);
        ntok = $urandom_range(4);
        bad_at = (r >= 65 && r < 80) ? $urandom_range(ntok) : -1;
        for (int i = 0; i <= ntok; i++) begin
            if (i == bad_at) add_bad_token();
            if (i < ntok) add_good_token();
        end
        frame.push_back(CH_QUOTE);
        if (r >= 80 && r < 88) begin
            cut = $urandom_range(frame.size() - 2);
            while (frame.size() > cut + 1) void'(frame.pop_back());
        end else if (r >= 88) begin
            k = $urandom_range(frame.size() - 1);
            frame[k] = 8'($urandom_range(255));
        end
    endfunction

    // ---------------- driving ----------------

    // Offer one byte, wait for the transaction, then record what it should give
    task automatic send_item(input logic [7:0] b, input logic l, input t_row_kind kind,
                             input logic [1:0] st, input logic [jsu_pkg::LEN_W-1:0] len);
        if ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        push <= 1'b1;
        i_in_byte <= b;
        i_in_last <= l;
        do @(posedge i_clk); while (full);
        unescape_byte(b, l);
        case (kind)
            ROW_PREDICT: foreach (step_out[i]) decoded_q.push_back(step_out[i]);
            ROW_RECORD:  decoded_q.push_back(t_result'{8'h00, st, len, 1'b1});
            default:     ;
        endcase
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame.size(); i++)
            send_item(frame[i], i == frame.size() - 1, ROW_PREDICT, jsu_pkg::ST_DATA, '0);
    endtask

    // Sender pauses until every expected result has come back
    task automatic drain();
        push <= 1'b0;
        do @(posedge i_clk); while (decoded_q.size() != 0);
    endtask

    // Receiver: random pops, plus a long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result checker
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && pop && !empty) begin
            got = t_result'{o_out_byte, o_status, o_total_length, o_last};
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, got data %h status %0d",
                         $time, got.data, got.status);
                $display("    length %0d last %0b", got.len, got.last);
                mismatch_count++;
            end else begin
                want = decoded_q.pop_front();
                if (got.data !== want.data || got.status !== want.status ||
                    got.len !== want.len || got.last !== want.last) begin
                    $display("%0t: mismatch: expected data %h status %0d length %0d last %0b,",
                             $time, want.data, want.status, want.len, want.last);
                    $display("    got data %h status %0d length %0d last %0b",
                             got.data, got.status, got.len, got.last);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: too many cycles without any transaction
    always @(posedge i_clk) begin : watchdog
        if ((push && !full) || (pop && !empty)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: timeout, %0d results outstanding", $time, decoded_q.size());
                $display("json_string_unescape_utf8_top regression: fail");
                $finish;
            end
        end
    end

    // Main sequence
    initial begin
        int sent;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < 26; i++)
            send_item(DIR_TAB[i].b, DIR_TAB[i].l, DIR_TAB[i].kind, DIR_TAB[i].status,
                      DIR_TAB[i].len);
        drain();

        // random payloads over the idling phases
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = SEND_IDLE[p];
            recv_stall_pct = RECV_STALL[p];
            if (p == 0) begin
                // receiver holds off while a long payload fills the block
                hold_reqs++;
                open_frame(30);
                frame.push_back(CH_QUOTE);
                send_frame();
            end
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                build_frame();
                send_frame();
                sent += frame.size();
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("json_string_unescape_utf8_top regression: pass");
        end else begin
            $display("json_string_unescape_utf8_top regression: fail");
        end
        $finish;
    end

endmodule
